>>> rtl/core/dmst_pkg.sv
// package for the duplicate-checking message slot table
// holds status and operation codes and parameter defaults; no dependencies
`timescale 1ns / 1ps

package dmst_pkg;

  // parameter defaults
  localparam int SlotCountDef = 16;
  localparam int TextBytesDef = 32;

  // operation codes
  localparam logic [1:0] OpAdd    = 2'd0;
  localparam logic [1:0] OpGet    = 2'd1;
  localparam logic [1:0] OpDelete = 2'd2;

  // result status codes
  localparam logic [2:0] StAdded     = 3'd0;
  localparam logic [2:0] StDup       = 3'd1;
  localparam logic [2:0] StFull      = 3'd2;
  localparam logic [2:0] StFound     = 3'd3;
  localparam logic [2:0] StNotFound  = 3'd4;
  localparam logic [2:0] StDeleted   = 3'd5;
  localparam logic [2:0] StBadIndex  = 3'd6;
  localparam logic [2:0] StBadClient = 3'd7;

endpackage

>>> rtl/core/dedup_message_slot_table.sv
// message slot table with duplicate check on add, get by client, delete by index
// depends on dmst_pkg
//
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid_i / in_stall_o   | opcode, sender_id, content_byte, slot_index
//  out     | output    | out_valid_o / out_stall_i | status, slot_out, text_byte, last
//
// an add byte that is not a terminator is staged directly; a delete or a reject is answered straight from idle.
// a terminator scans the slots one per cycle, and for each slot of the same client reads then
// checks each byte compared (S_DUP_RD, S_DUP_CHK); it then scans one slot per cycle for a
// free one, reads then writes each byte to copy (S_CP_RD, S_CP_WR) and answers from S_RESP.
// a get scans one slot per cycle, then reads and sends each byte, or answers not found.
// reset empties every slot and the staging buffer at once; no clearing pass is needed.
// a stalled output holds the block: the next item is taken only when the result can leave.
`timescale 1ns / 1ps

module dedup_message_slot_table #(
  parameter int SlotCount = dmst_pkg::SlotCountDef,
  parameter int TextBytes = dmst_pkg::TextBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] sender_id_i,
  input  logic [7:0] content_byte_i,
  input  logic [7:0] slot_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic [3:0] slot_out_o,
  output logic [7:0] text_byte_o,
  output logic       last_o
);
  import dmst_pkg::*;

  localparam int SW = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int PW = $clog2(TextBytes);
  localparam int AW = (SlotCount * TextBytes > 1) ? $clog2(SlotCount * TextBytes) : 1;
  localparam logic [SW-1:0] SlotLast = SW'(SlotCount - 1);
  localparam logic [PW-1:0] PosLast  = PW'(TextBytes - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DUP_SCAN, S_DUP_RD, S_DUP_CHK, S_FREE_SCAN, S_CP_RD, S_CP_WR,
    S_GET_SCAN, S_GET_RD, S_GET_OUT, S_RESP
  } state_e;

  state_e           state_q;
  logic [7:0]       owner_q [SlotCount];
  logic [PW-1:0]    len_q;
  logic             overlong_q;
  logic [7:0]       client_q;
  logic [SW-1:0]    slot_q;
  logic [PW-1:0]    pos_q;
  logic [2:0]       resp_status_q;
  logic [SW-1:0]    resp_slot_q;
  logic             out_valid_q;
  logic [2:0]       status_q;
  logic [3:0]       slot_out_q;
  logic [7:0]       text_byte_q;
  logic             last_q;

  // memories
  logic [7:0]       text_mem [SlotCount * TextBytes];
  logic [7:0]       stag_mem [TextBytes];
  logic [7:0]       text_rd_q;
  logic [7:0]       stag_rd_q;

  logic             accept;
  logic             out_free;
  logic [AW-1:0]    rd_addr;
  logic [7:0]       exp_byte;
  logic             text_we;
  logic [AW-1:0]    text_waddr;
  logic [7:0]       text_wdata;
  logic             stag_we;
  logic             idx_ok;
  logic             get_end;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  // address of the current slot byte and the staged byte it is compared with
  assign rd_addr  = AW'(int'(slot_q) * TextBytes + int'(pos_q));
  assign exp_byte = (pos_q == len_q) ? 8'd0 : stag_rd_q;
  assign idx_ok   = {1'b0, slot_index_i} < 9'(SlotCount);
  assign get_end  = (text_rd_q == 8'd0) || (pos_q == PosLast);

  // write port of the text memory: copy on add, terminator at offset zero on delete
  always_comb begin
    text_we    = 1'b0;
    text_waddr = rd_addr;
    text_wdata = exp_byte;
    if (state_q == S_CP_WR) begin
      text_we = 1'b1;
    end else if (accept && opcode_i == OpDelete && idx_ok) begin
      text_we    = 1'b1;
      text_waddr = AW'(int'(slot_index_i[SW-1:0]) * TextBytes);
      text_wdata = 8'd0;
    end
  end

  assign stag_we = accept && opcode_i == OpAdd && content_byte_i != 8'd0 && len_q < PosLast;

  always_ff @(posedge clk_i) begin
    if (text_we) begin
      text_mem[text_waddr] <= text_wdata;
    end
    text_rd_q <= text_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (stag_we) begin
      stag_mem[len_q] <= content_byte_i;
    end
    stag_rd_q <= stag_mem[pos_q];
  end

  // control, slot owners and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      for (int i = 0; i < SlotCount; i++) owner_q[i] <= 8'd0;
      len_q         <= '0;
      overlong_q    <= 1'b0;
      client_q      <= 8'd0;
      slot_q        <= '0;
      pos_q         <= '0;
      resp_status_q <= StAdded;
      resp_slot_q   <= '0;
      out_valid_q   <= 1'b0;
      status_q      <= StAdded;
      slot_out_q    <= 4'd0;
      text_byte_q   <= 8'd0;
      last_q        <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (opcode_i)
              OpAdd: begin
                if (content_byte_i != 8'd0) begin
                  if (len_q < PosLast) len_q <= len_q + 1'b1;
                  else overlong_q <= 1'b1;
                end else if (sender_id_i == 8'd0) begin
                  len_q       <= '0;
                  overlong_q  <= 1'b0;
                  out_valid_q <= 1'b1;
                  status_q    <= StBadClient;
                  slot_out_q  <= 4'd0;
                  text_byte_q <= 8'd0;
                  last_q      <= 1'b1;
                end else begin
                  client_q <= sender_id_i;
                  slot_q   <= '0;
                  state_q  <= S_DUP_SCAN;
                end
              end
              OpGet: begin
                if (sender_id_i == 8'd0) begin
                  out_valid_q <= 1'b1;
                  status_q    <= StBadClient;
                  slot_out_q  <= 4'd0;
                  text_byte_q <= 8'd0;
                  last_q      <= 1'b1;
                end else begin
                  client_q <= sender_id_i;
                  slot_q   <= '0;
                  state_q  <= S_GET_SCAN;
                end
              end
              OpDelete: begin
                out_valid_q <= 1'b1;
                text_byte_q <= 8'd0;
                last_q      <= 1'b1;
                if (idx_ok) begin
                  owner_q[slot_index_i[SW-1:0]] <= 8'd0;
                  status_q   <= StDeleted;
                  slot_out_q <= slot_index_i[3:0];
                end else begin
                  status_q   <= StBadIndex;
                  slot_out_q <= 4'd0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        // look for a slot of this client holding the same text
        S_DUP_SCAN: begin
          if (owner_q[slot_q] == client_q && !overlong_q) begin
            pos_q   <= '0;
            state_q <= S_DUP_RD;
          end else if (slot_q == SlotLast) begin
            slot_q  <= '0;
            state_q <= S_FREE_SCAN;
          end else begin
            slot_q <= slot_q + 1'b1;
          end
        end
        S_DUP_RD: state_q <= S_DUP_CHK;
        S_DUP_CHK: begin
          if (text_rd_q != exp_byte) begin
            if (slot_q == SlotLast) begin
              slot_q  <= '0;
              state_q <= S_FREE_SCAN;
            end else begin
              slot_q  <= slot_q + 1'b1;
              state_q <= S_DUP_SCAN;
            end
          end else if (pos_q == len_q) begin
            len_q         <= '0;
            overlong_q    <= 1'b0;
            resp_status_q <= StDup;
            resp_slot_q   <= '0;
            state_q       <= S_RESP;
          end else begin
            pos_q   <= pos_q + 1'b1;
            state_q <= S_DUP_RD;
          end
        end
        // lowest empty slot takes the text
        S_FREE_SCAN: begin
          if (owner_q[slot_q] == 8'd0) begin
            owner_q[slot_q] <= client_q;
            pos_q           <= '0;
            state_q         <= S_CP_RD;
          end else if (slot_q == SlotLast) begin
            len_q         <= '0;
            overlong_q    <= 1'b0;
            resp_status_q <= StFull;
            resp_slot_q   <= '0;
            state_q       <= S_RESP;
          end else begin
            slot_q <= slot_q + 1'b1;
          end
        end
        S_CP_RD: state_q <= S_CP_WR;
        S_CP_WR: begin
          if (pos_q == len_q) begin
            len_q         <= '0;
            overlong_q    <= 1'b0;
            resp_status_q <= StAdded;
            resp_slot_q   <= slot_q;
            state_q       <= S_RESP;
          end else begin
            pos_q   <= pos_q + 1'b1;
            state_q <= S_CP_RD;
          end
        end
        // lowest slot owned by the client
        S_GET_SCAN: begin
          if (owner_q[slot_q] == client_q) begin
            pos_q   <= '0;
            state_q <= S_GET_RD;
          end else if (slot_q == SlotLast) begin
            resp_status_q <= StNotFound;
            resp_slot_q   <= '0;
            state_q       <= S_RESP;
          end else begin
            slot_q <= slot_q + 1'b1;
          end
        end
        S_GET_RD: state_q <= S_GET_OUT;
        S_GET_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= StFound;
            slot_out_q  <= 4'(slot_q);
            text_byte_q <= get_end ? 8'd0 : text_rd_q;
            last_q      <= get_end;
            if (get_end) begin
              state_q <= S_IDLE;
            end else begin
              pos_q   <= pos_q + 1'b1;
              state_q <= S_GET_RD;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= resp_status_q;
            slot_out_q  <= 4'(resp_slot_q);
            text_byte_q <= 8'd0;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_out_o  = slot_out_q;
  assign text_byte_o = text_byte_q;
  assign last_o      = last_q;

  // checks
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> state_q == S_IDLE) else $error("item taken while busy");
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= PosLast) else $error("staging length out of range");
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != StFound |-> last_q) else $error("lone result not last");
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != StFound |-> text_byte_q == 8'd0)
    else $error("text byte on non-found result");
  a_end_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RESP && out_free |=> state_q == S_IDLE) else $error("response not closed");

endmodule
